// ===== design/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned PROD_W   = 2 * ELEM_W;
  localparam int unsigned COF_W    = PROD_W + 1;
  localparam int unsigned DTERM_W  = ELEM_W + COF_W;
  localparam int unsigned DET_W    = DTERM_W + 2;
  localparam int unsigned UCOF_W   = PROD_W;
  localparam int unsigned UDET_W   = DET_W - 1;
  localparam int unsigned D_W      = UDET_W + 1;
  localparam int unsigned R_W      = D_W;
  localparam int unsigned QW       = OUT_W;
  localparam int unsigned FRAC_SH  = 29;
  localparam int unsigned N_W      = UCOF_W + FRAC_SH + 1;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // cofactor k = m[a]*m[b] - m[c]*m[d], sign of the adjugate folded in
  localparam int unsigned COF_A [NUM_ELEM] = '{4, 7, 1, 5, 0, 3, 3, 6, 0};
  localparam int unsigned COF_B [NUM_ELEM] = '{8, 2, 5, 6, 8, 2, 7, 1, 4};
  localparam int unsigned COF_C [NUM_ELEM] = '{7, 1, 2, 3, 6, 0, 6, 0, 1};
  localparam int unsigned COF_D [NUM_ELEM] = '{5, 8, 4, 8, 2, 5, 4, 7, 3};

  typedef struct packed {
    logic signed [ELEM_W-1:0] in_e0;
    logic signed [ELEM_W-1:0] in_e1;
    logic signed [ELEM_W-1:0] in_e2;
    logic signed [ELEM_W-1:0] in_e3;
    logic signed [ELEM_W-1:0] in_e4;
    logic signed [ELEM_W-1:0] in_e5;
    logic signed [ELEM_W-1:0] in_e6;
    logic signed [ELEM_W-1:0] in_e7;
    logic signed [ELEM_W-1:0] in_e8;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_e0;
    logic signed [OUT_W-1:0] out_e1;
    logic signed [OUT_W-1:0] out_e2;
    logic signed [OUT_W-1:0] out_e3;
    logic signed [OUT_W-1:0] out_e4;
    logic signed [OUT_W-1:0] out_e5;
    logic signed [OUT_W-1:0] out_e6;
    logic signed [OUT_W-1:0] out_e7;
    logic signed [OUT_W-1:0] out_e8;
    logic                    singular;
  } out_t;

  typedef struct packed {
    logic [NUM_ELEM-1:0][R_W-1:0] r;
    logic [NUM_ELEM-1:0][QW-1:0]  nl;
    logic [NUM_ELEM-1:0][QW-1:0]  q;
    logic [D_W-1:0]               d;
    logic [NUM_ELEM-1:0]          neg;
    logic [NUM_ELEM-1:0]          ovf;
    logic                         sing;
  } div_t;

endpackage

// ===== design/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed Q4.12 3x3 matrix by adjugate, Q16.16 saturated result.
//
//   channel  valid        stall        payload
//   in       in_valid_i   in_stall_o   in_data_i   (mi3_pkg::in_t)
//   out      out_valid_o  out_stall_i  out_data_o  (mi3_pkg::out_t)
//
// one matrix per cycle while the output is not stalled: 4 cofactor/determinant stages,
// 2 divider setup stages, 32 restoring divider stages, 1 output stage
// the whole pipeline advances when the output register is empty or taken
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mi3_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mi3_pkg::out_t  out_data_o
);
  import mi3_pkg::*;

  logic                    en;
  logic                    front_valid;
  logic signed [COF_W-1:0] cof [NUM_ELEM];
  logic signed [DET_W-1:0] det;
  logic                    div_valid [QW+1];
  div_t                    div_s     [QW+1];
  logic [OUT_W-1:0]        res [NUM_ELEM];
  out_t                    out_d;
  out_t                    out_q;
  logic                    out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (front_valid),
    .cof_o   (cof),
    .det_o   (det)
  );

  mi3_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .cof_i   (cof),
    .det_i   (det),
    .valid_o (div_valid[0]),
    .data_o  (div_s[0])
  );

  for (genvar s = 0; s < QW; s++) begin : g_div
    mi3_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[s]),
      .data_i  (div_s[s]),
      .valid_o (div_valid[s+1]),
      .data_o  (div_s[s+1])
    );
  end

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_res
    always_comb begin
      priority if (div_s[QW].sing) begin
        res[k] = '0;
      end else if (div_s[QW].ovf[k]) begin
        res[k] = div_s[QW].neg[k] ? SAT_MIN : SAT_MAX;
      end else if (div_s[QW].neg[k]) begin
        res[k] = (div_s[QW].q[k] > SAT_MIN) ? SAT_MIN : OUT_W'(-div_s[QW].q[k]);
      end else begin
        res[k] = div_s[QW].q[k][QW-1] ? SAT_MAX : div_s[QW].q[k];
      end
    end
  end

  always_comb begin
    out_d          = '0;
    out_d.out_e0   = res[0];
    out_d.out_e1   = res[1];
    out_d.out_e2   = res[2];
    out_d.out_e3   = res[3];
    out_d.out_e4   = res[4];
    out_d.out_e5   = res[5];
    out_d.out_e6   = res[6];
    out_d.out_e7   = res[7];
    out_d.out_e8   = res[8];
    out_d.singular = div_s[QW].sing;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid[QW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.out_e0 == '0 && out_data_o.out_e4 == '0 && out_data_o.out_e8 == '0)
    else $error("singular result with nonzero diagonal");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(div_valid[QW]))
    else $error("divider moved while pipeline stalled");
`endif

endmodule

// ===== design/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Four stages: 2x2 products, cofactors, determinant terms, determinant.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  mi3_pkg::in_t                             data_i,
  output logic                                     valid_o,
  output logic signed [mi3_pkg::COF_W-1:0]         cof_o [mi3_pkg::NUM_ELEM],
  output logic signed [mi3_pkg::DET_W-1:0]         det_o
);
  import mi3_pkg::*;

  logic signed [ELEM_W-1:0]  m      [NUM_ELEM];
  logic signed [PROD_W-1:0]  pa_q   [NUM_ELEM];
  logic signed [PROD_W-1:0]  pb_q   [NUM_ELEM];
  logic signed [COF_W-1:0]   cof2_q [NUM_ELEM];
  logic signed [COF_W-1:0]   cof3_q [NUM_ELEM];
  logic signed [COF_W-1:0]   cof4_q [NUM_ELEM];
  logic signed [ELEM_W-1:0]  mh1_q  [3];
  logic signed [ELEM_W-1:0]  mh2_q  [3];
  logic signed [DTERM_W-1:0] dt_q   [3];
  logic signed [DET_W-1:0]   det_d;
  logic signed [DET_W-1:0]   det_q;
  logic [3:0]                v_q;

  assign m[0] = data_i.in_e0;
  assign m[1] = data_i.in_e1;
  assign m[2] = data_i.in_e2;
  assign m[3] = data_i.in_e3;
  assign m[4] = data_i.in_e4;
  assign m[5] = data_i.in_e5;
  assign m[6] = data_i.in_e6;
  assign m[7] = data_i.in_e7;
  assign m[8] = data_i.in_e8;

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_cof
    logic signed [PROD_W-1:0] pa_d;
    logic signed [PROD_W-1:0] pb_d;
    assign pa_d = m[COF_A[k]] * m[COF_B[k]];
    assign pb_d = m[COF_C[k]] * m[COF_D[k]];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q[k]   <= pa_d;
        pb_q[k]   <= pb_d;
        cof2_q[k] <= {pa_q[k][PROD_W-1], pa_q[k]} - {pb_q[k][PROD_W-1], pb_q[k]};
        cof3_q[k] <= cof2_q[k];
        cof4_q[k] <= cof3_q[k];
      end
    end
    assign cof_o[k] = cof4_q[k];
  end

  for (genvar j = 0; j < 3; j++) begin : g_dterm
    logic signed [DTERM_W-1:0] dt_d;
    assign dt_d = mh2_q[j] * cof2_q[3*j];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mh1_q[j] <= m[j];
        mh2_q[j] <= mh1_q[j];
        dt_q[j]  <= dt_d;
      end
    end
  end

  assign det_d = DET_W'(dt_q[0]) + DET_W'(dt_q[1]) + DET_W'(dt_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= det_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign valid_o = v_q[3];
  assign det_o   = det_q;

endmodule

// ===== design/mi3_prep.sv =====
// ----------------------------------------------------------------------------
// mi3_prep
// Two stages: magnitudes and signs, then rounded dividend, divisor and
// quotient overflow check.
// ----------------------------------------------------------------------------
module mi3_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [mi3_pkg::COF_W-1:0] cof_i [mi3_pkg::NUM_ELEM],
  input  logic signed [mi3_pkg::DET_W-1:0] det_i,
  output logic                             valid_o,
  output mi3_pkg::div_t                    data_o
);
  import mi3_pkg::*;

  logic [UCOF_W-1:0]   ucof_q [NUM_ELEM];
  logic [UDET_W-1:0]   ud_q;
  logic [NUM_ELEM-1:0] neg_q;
  logic                sing_q;
  logic [D_W-1:0]      d;
  div_t                data_d;
  div_t                data_q;
  logic [1:0]          v_q;

  assign d = {ud_q, 1'b0};

  always_comb begin
    data_d      = '0;
    data_d.d    = d;
    data_d.neg  = neg_q;
    data_d.sing = sing_q;
    for (int k = 0; k < NUM_ELEM; k++) begin
      logic [N_W-1:0] n;
      n = N_W'({ucof_q[k], {FRAC_SH{1'b0}}}) + N_W'(ud_q);
      data_d.r[k]   = R_W'(n[N_W-1:QW]);
      data_d.nl[k]  = n[QW-1:0];
      data_d.ovf[k] = D_W'(n[N_W-1:QW]) >= d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        ucof_q[k] <= cof_i[k][COF_W-1] ? UCOF_W'(-cof_i[k]) : cof_i[k][UCOF_W-1:0];
        neg_q[k]  <= cof_i[k][COF_W-1] ^ det_i[DET_W-1];
      end
      ud_q   <= det_i[DET_W-1] ? UDET_W'(-det_i) : det_i[UDET_W-1:0];
      sing_q <= (det_i == '0);
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  assign valid_o = v_q[1];
  assign data_o  = data_q;

endmodule

// ===== design/mi3_div_step.sv =====
// ----------------------------------------------------------------------------
// mi3_div_step
// One restoring division step for all nine lanes, one quotient bit each.
// ----------------------------------------------------------------------------
module mi3_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  mi3_pkg::div_t data_i,
  output logic          valid_o,
  output mi3_pkg::div_t data_o
);
  import mi3_pkg::*;

  div_t data_d;
  div_t data_q;
  logic valid_q;

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < NUM_ELEM; k++) begin
      logic [R_W:0] t;
      logic         ge;
      t  = {data_i.r[k], data_i.nl[k][QW-1]};
      ge = t >= {1'b0, data_i.d};
      data_d.r[k]  = ge ? R_W'(t - {1'b0, data_i.d}) : t[R_W-1:0];
      data_d.nl[k] = {data_i.nl[k][QW-2:0], 1'b0};
      data_d.q[k]  = {data_i.q[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== test/tb_matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Feeds directed and random 3x3 Q4.12 matrices through the inverse pipeline
// with random gaps on both channels and one long output hold-off, and checks
// every transfer against an exact integer adjugate/determinant predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;
  import mi3_pkg::*;

  localparam int NUM_RAND = 500;
  localparam int LATENCY  = 39;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;

  out_t  inverse_q[$];
  int    n_errors = 0;
  int    n_sent = 0;
  int    n_recv = 0;
  int    n_singular = 0;
  int    n_saturated = 0;
  bit    feed_done = 1'b0;
  bit    hold_off = 1'b0;

  typedef struct {
    logic [15:0] e[9];
    bit          fixed;
    out_t        res;
  } row_t;
  row_t dir_rows[$];

  matrix3x3_inverse dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint div_round_sat(longint num, longint den);
    bit     neg;
    longint un, ud, q;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un * 2 + ud) / (ud * 2);
    if (neg) return (q > 64'sh80000000) ? -64'sh80000000 : -q;
    return (q > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF : q;
  endfunction

  function automatic out_t invert(in_t a);
    longint m[9];
    longint cof[9];
    longint det;
    logic [31:0] v[9];
    out_t r;
    m[0] = longint'(a.in_e0); m[1] = longint'(a.in_e1); m[2] = longint'(a.in_e2);
    m[3] = longint'(a.in_e3); m[4] = longint'(a.in_e4); m[5] = longint'(a.in_e5);
    m[6] = longint'(a.in_e6); m[7] = longint'(a.in_e7); m[8] = longint'(a.in_e8);
    det = m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
        - m[6]*m[4]*m[2] - m[7]*m[5]*m[0] - m[8]*m[3]*m[1];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    cof[0] = m[4]*m[8] - m[7]*m[5];
    cof[1] = -(m[1]*m[8] - m[7]*m[2]);
    cof[2] = m[1]*m[5] - m[2]*m[4];
    cof[3] = -(m[3]*m[8] - m[5]*m[6]);
    cof[4] = m[0]*m[8] - m[6]*m[2];
    cof[5] = -(m[0]*m[5] - m[3]*m[2]);
    cof[6] = m[3]*m[7] - m[6]*m[4];
    cof[7] = -(m[0]*m[7] - m[6]*m[1]);
    cof[8] = m[0]*m[4] - m[1]*m[3];
    for (int k = 0; k < 9; k++) v[k] = 32'(div_round_sat(cof[k] * (64'sd1 << 28), det));
    r.out_e0 = v[0]; r.out_e1 = v[1]; r.out_e2 = v[2];
    r.out_e3 = v[3]; r.out_e4 = v[4]; r.out_e5 = v[5];
    r.out_e6 = v[6]; r.out_e7 = v[7]; r.out_e8 = v[8];
    return r;
  endfunction

  function automatic in_t pack_matrix(logic [15:0] e[9]);
    in_t a;
    a = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return a;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_elem();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return 16'($urandom);
    if (p < 8) return 16'($signed($urandom_range(0, 16)) - 8) <<< 12;
    return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
  endfunction

  task automatic add_row(input logic [15:0] e[9], input bit fixed, input out_t res);
    row_t r;
    r.e = e;
    r.fixed = fixed;
    r.res = res;
    dir_rows.push_back(r);
  endtask

  task automatic send(input in_t a);
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    do @(posedge clk_i); while (in_stall_o);
    inverse_q.push_back(invert(a));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic build_directed();
    out_t z;
    out_t id;
    z = '0;
    z.singular = 1'b1;
    id = '0;
    id.out_e0 = 32'h00010000; id.out_e4 = 32'h00010000; id.out_e8 = 32'h00010000;
    add_row('{default: 16'h0000}, 1'b1, z);
    add_row('{16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000}, 1'b1, id);
    add_row('{default: 16'h7FFF}, 1'b1, z);
    add_row('{default: 16'h8000}, 1'b1, z);
    add_row('{default: 16'hFFFF}, 1'b1, z);
    add_row('{16'h1000, 16'h2000, 0, 16'h2000, 16'h4000, 0, 0, 0, 16'h1000}, 1'b1, z);
    add_row('{16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001}, 1'b0, z);
    add_row('{16'h0001, 0, 0, 0, 16'hFFFF, 0, 0, 0, 16'h0001}, 1'b0, z);
    add_row('{16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h7FFF}, 1'b0, z);
    add_row('{16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0, 16'h8000}, 1'b0, z);
    add_row('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h8000, 16'h8000, 16'h7FFF}, 1'b0, z);
    add_row('{0, 16'h1000, 0, 0, 0, 16'h1000, 16'h1000, 0, 0}, 1'b0, z);
    add_row('{16'h3000, 0, 0, 0, 16'h3000, 0, 0, 0, 16'h3000}, 1'b0, z);
    add_row('{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h1234, 16'hEDCB,
              16'h7F01, 16'h80FE, 16'h0101}, 1'b0, z);
    add_row('{16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 16'hEDCB, 16'h1234,
              16'h80FE, 16'h7F01, 16'hFEFE}, 1'b0, z);
  endtask

  initial begin
    logic [15:0] e[9];
    build_directed();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fixed) begin
        if (dir_rows[i].res !== invert(pack_matrix(dir_rows[i].e))) begin
          $error("directed row %0d: typed result disagrees with predictor", i);
          n_errors++;
        end
      end
      send(pack_matrix(dir_rows[i].e));
    end
    for (int i = 0; i < NUM_RAND; i++) begin
      int g;
      for (int k = 0; k < 9; k++) e[k] = rand_elem();
      if ($urandom_range(0, 9) == 0) begin
        for (int k = 0; k < 3; k++) e[3 + k] = e[k];
      end
      g = (i >= 150 && i < 260) ? 0 : gap_len();
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      send(pack_matrix(e));
    end
    in_valid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // long output hold-off while the sender keeps streaming
  initial begin
    wait (n_sent >= 160);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (120) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_stall_i <= 1'b1;
          repeat (g - 1) @(negedge clk_i);
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_recv++;
      if (inverse_q.size() == 0) begin
        $error("transfer with no matrix outstanding: %h", out_data_o);
        n_errors++;
      end else begin
        x = inverse_q.pop_front();
        check_field("out_e0", x.out_e0, out_data_o.out_e0);
        check_field("out_e1", x.out_e1, out_data_o.out_e1);
        check_field("out_e2", x.out_e2, out_data_o.out_e2);
        check_field("out_e3", x.out_e3, out_data_o.out_e3);
        check_field("out_e4", x.out_e4, out_data_o.out_e4);
        check_field("out_e5", x.out_e5, out_data_o.out_e5);
        check_field("out_e6", x.out_e6, out_data_o.out_e6);
        check_field("out_e7", x.out_e7, out_data_o.out_e7);
        check_field("out_e8", x.out_e8, out_data_o.out_e8);
        check_field("singular", 32'(x.singular), 32'(out_data_o.singular));
        if (x.singular) n_singular++;
        if (x.out_e0 == SAT_MAX || x.out_e0 == SAT_MIN) n_saturated++;
      end
    end
  end

  initial begin
    wait (feed_done);
    while (n_recv < n_sent) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("%0d matrices inverted and checked, %0d singular, %0d saturated in element 0",
             n_recv, n_singular, n_saturated);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d matrices outstanding", inverse_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
